>>> hw/rtl/smtoa_pkg.sv
// Shared types, widths and codes of the SMT overlap time accounter.
package smtoa_pkg;

  // Field widths fixed by the item formats.
  localparam int THR_W    = 4;
  localparam int ACT_W    = 2;
  localparam int TS_W     = 63;
  localparam int TOTAL_W  = 64;

  // Core pairs and threads; the thread index width covers all threads.
  localparam int CORE_PAIRS = 8;
  localparam int THREADS    = 2 * CORE_PAIRS;
  localparam int PAIR_W     = THR_W - 1;

  // Configuration port geometry.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_PAIR_ENABLE_MASK = 1'b0;

  // Switch kinds.
  localparam logic [ACT_W-1:0] ACT_IDLE_TO_BUSY = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BUSY_TO_IDLE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BUSY_TO_BUSY = 2'd2;
  localparam logic [ACT_W-1:0] ACT_SAME_TASK    = 2'd3;

  localparam logic [TS_W-1:0] DELTA_MAX = {TS_W{1'b1}};

  // Control state.
  typedef enum logic {
    ST_IDLE,
    ST_FOLD
  } state_t;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [CORE_PAIRS-1:0] pair_enable_mask;
  } cfg_t;

  // One accepted switch request.
  typedef struct packed {
    logic [THR_W-1:0] thread_index;
    logic [ACT_W-1:0] action;
    logic [TS_W-1:0]  timestamp_ns;
    logic             has_group;
  } in_item_t;

  // Per-pair memory entry.
  typedef struct packed {
    logic [TS_W-1:0]    start;
    logic [TOTAL_W-1:0] total;
  } pair_entry_t;

endpackage

>>> hw/rtl/smtoa_if.sv
// Request channels of the accounter: switch requests in, charge results out.
interface smtoa_in_if import smtoa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] thread_index;
  logic [ACT_W-1:0] action;
  logic [TS_W-1:0]  timestamp_ns;
  logic             has_group;

  modport source (output valid, thread_index, action, timestamp_ns, has_group, input ready);
  modport sink   (input valid, thread_index, action, timestamp_ns, has_group, output ready);
endinterface

interface smtoa_out_if import smtoa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] charged_thread;
  logic [TS_W-1:0]  overlap_delta_ns;

  modport source (output valid, charged_thread, overlap_delta_ns, input ready);
  modport sink   (input valid, charged_thread, overlap_delta_ns, output ready);
endinterface

>>> hw/rtl/smt_overlap_time_accounter.sv
// Top level of the SMT overlap time accounter: registers and read-modify-write engine.
// A request is captured when accepted; its result is registered when its fold ends.
// A new request is taken only in idle, after the fold of the last one has finished.
// A grouped result that finds the output register full waits in the fold until it frees.
// Reset clears the state machine, the enable mask, busy flags and the memory valid bits,
// so every memory entry reads as zero at once; there is no clearing pass.
module smt_overlap_time_accounter import smtoa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  smtoa_in_if.sink          in_chan,
  smtoa_out_if.source       out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  // Configuration registers.
  smtoa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Accounting engine.
  smtoa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule

>>> hw/rtl/smtoa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module smtoa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/smtoa_regs.sv
// APB-style configuration register block holding the pair enable mask.
module smtoa_regs import smtoa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [CORE_PAIRS-1:0] pair_enable_mask;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_enable_mask <= '0;
    end else if (wr_en && paddr[ADDR_W-1:2] == REG_PAIR_ENABLE_MASK) begin
      pair_enable_mask <= pwdata[CORE_PAIRS-1:0];
    end
  end

  // Read data.
  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_PAIR_ENABLE_MASK) begin
      prdata[CORE_PAIRS-1:0] = pair_enable_mask;
    end
  end

  assign cfg.pair_enable_mask = pair_enable_mask;

endmodule

>>> hw/rtl/smtoa_ctrl.sv
// Read-modify-write engine over the pair and thread memories, with result register.
module smtoa_ctrl import smtoa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  smtoa_in_if.sink     in_chan,
  smtoa_out_if.source  out_chan
);

  state_t state, state_next;
  in_item_t item;

  logic                  in_fire;
  logic                  finish;
  logic                  has_result;

  // Valid bits stand for the zero reset of both memories.
  logic [CORE_PAIRS-1:0] pair_valid;
  logic [THREADS-1:0]    thr_valid;
  logic [THREADS-1:0]    thread_busy;

  logic [TOTAL_W-1:0]    pair_rdata_raw;
  pair_entry_t           pair_rdata;
  pair_entry_t           pair_wdata;
  logic [TOTAL_W-1:0]    last_rdata;
  logic                  pair_we;
  logic                  thr_we;

  logic [PAIR_W-1:0]     pair;
  logic [THR_W-1:0]      sib;
  logic                  enabled;
  logic [TS_W-1:0]       start_cur;
  logic [TOTAL_W-1:0]    total_cur;
  logic [TOTAL_W-1:0]    last_cur;
  logic [TOTAL_W-1:0]    diff;
  logic                  open_iv;
  logic                  later;
  logic [TS_W-1:0]       start_new;
  logic [TOTAL_W-1:0]    total_new;
  logic [TOTAL_W-1:0]    growth;
  logic                  is_leave;

  logic                  out_valid;
  logic [THR_W-1:0]      out_thread;
  logic [TS_W-1:0]       out_delta;

  logic [$bits(pair_entry_t)-1:0] pair_rvec;

  assign in_fire = in_chan.valid && in_chan.ready;

  // Memories: one entry per pair, one per thread.
  smtoa_ram #(.WIDTH($bits(pair_entry_t)), .DEPTH(CORE_PAIRS)) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair),
    .wdata (pair_wdata),
    .re    (in_fire),
    .raddr (in_chan.thread_index[THR_W-1:1]),
    .rdata (pair_rvec)
  );

  smtoa_ram #(.WIDTH(TOTAL_W), .DEPTH(THREADS)) u_thr_ram (
    .clk   (clk),
    .we    (thr_we),
    .waddr (item.thread_index),
    .wdata (total_new),
    .re    (in_fire),
    .raddr (in_chan.thread_index),
    .rdata (last_rdata)
  );

  assign pair_rdata     = pair_entry_t'(pair_rvec);
  assign pair_rdata_raw = pair_rdata.total;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_fire) state_next = ST_FOLD;
      ST_FOLD: if (finish) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs; no request is taken while reset is held.
  always_comb begin
    in_chan.ready = 1'b0;
    finish        = 1'b0;
    case (state)
      ST_IDLE: in_chan.ready = !rst;
      ST_FOLD: finish = !(has_result && out_valid && !out_chan.ready);
      default: in_chan.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the accepted request.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item.thread_index <= in_chan.thread_index;
      item.action       <= in_chan.action;
      item.timestamp_ns <= in_chan.timestamp_ns;
      item.has_group    <= in_chan.has_group;
    end
  end

  // Current values; an entry never written reads as zero.
  assign pair      = item.thread_index[THR_W-1:1];
  assign sib       = {item.thread_index[THR_W-1:1], ~item.thread_index[0]};
  assign enabled   = cfg.pair_enable_mask[pair];
  assign start_cur = pair_valid[pair] ? pair_rdata.start : '0;
  assign total_cur = pair_valid[pair] ? pair_rdata_raw : '0;
  assign last_cur  = thr_valid[item.thread_index] ? last_rdata : '0;

  // Open a new overlap interval, or fold the open one into the pair total.
  assign diff     = {1'b0, item.timestamp_ns} - {1'b0, start_cur};
  assign open_iv  = start_cur != '0;
  assign later    = !diff[TOTAL_W-1] && diff != '0;
  assign is_leave = item.action == ACT_BUSY_TO_IDLE || item.action == ACT_BUSY_TO_BUSY;

  always_comb begin
    start_new = start_cur;
    total_new = total_cur;
    case (item.action)
      ACT_IDLE_TO_BUSY: begin
        if (thread_busy[sib]) start_new = item.timestamp_ns;
      end
      ACT_BUSY_TO_IDLE: begin
        start_new = '0;
        if (open_iv && later) total_new = total_cur + diff;
      end
      ACT_BUSY_TO_BUSY: begin
        if (open_iv && later) begin
          start_new = item.timestamp_ns;
          total_new = total_cur + diff;
        end
      end
      default: start_new = start_cur;
    endcase
  end

  // Growth since the thread's last report.
  assign growth     = total_new - last_cur;
  assign has_result = enabled && is_leave && item.has_group && growth != '0;

  assign pair_wdata.start = start_new;
  assign pair_wdata.total = total_new;
  assign pair_we = finish && enabled && item.action != ACT_SAME_TASK;
  assign thr_we  = finish && has_result;

  // Busy flags and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      thread_busy <= '0;
      pair_valid  <= '0;
      thr_valid   <= '0;
    end else begin
      if (pair_we) begin
        pair_valid[pair] <= 1'b1;
        if (item.action == ACT_IDLE_TO_BUSY) thread_busy[item.thread_index] <= 1'b1;
        if (item.action == ACT_BUSY_TO_IDLE) thread_busy[item.thread_index] <= 1'b0;
      end
      if (thr_we) begin
        thr_valid[item.thread_index] <= 1'b1;
      end
    end
  end

  // Result register; a waiting result holds back only a fold that has a charge of its own.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (thr_we) begin
      out_valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (thr_we) begin
      out_thread <= item.thread_index;
      out_delta  <= growth[TOTAL_W-1] ? DELTA_MAX : growth[TS_W-1:0];
    end
  end

  assign out_chan.valid            = out_valid;
  assign out_chan.charged_thread   = out_thread;
  assign out_chan.overlap_delta_ns = out_delta;

  // A new result is loaded only at the end of a fold.
  a_result_from_fold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FOLD))
    else $error("result appeared without a finished fold");

  // A fold is always entered from an accepted request.
  a_fold_after_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FOLD && $past(state == ST_IDLE)) |-> $past(in_fire))
    else $error("fold started without a request");

  // A stalled fold keeps its request and stays in place.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FOLD && !finish) |=> (state == ST_FOLD && $stable(item)))
    else $error("stalled fold lost its request");

  // Only a grouped leaving switch on a tracked pair charges a thread.
  a_charge_kind: assert property (@(posedge clk) disable iff (rst)
    thr_we |-> (pair_we && item.has_group && is_leave))
    else $error("charge from a switch that cannot charge");

endmodule
